[hdl/lcs_pkg.sv]
// Shared types and constants for the longest common subsequence block.
package lcs_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned CMD_W = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned POS_W = 6;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_X = 2'd0,
    CMD_APPEND_Y = 2'd1,
    CMD_COMPUTE  = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // Traceback direction stored for each table cell.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_UP   = 2'd2,
    DIR_LEFT = 2'd3
  } dir_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_CHECK,
    S_TB_RD,
    S_TB_STEP,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMPTY
  } state_e;

endpackage

[hdl/longest_common_subsequence.sv]
// Top level: symbol stores, systolic cell chain, traceback and result sequencer.
// Append requests are accepted only while idle.
// A compute with both sequences non-empty fills the length table through the cell chain,
// then walks the traceback (read, step) and emits each result (read, output).
// Each cell owns one X symbol and one direction column memory; the chain sets fill time.
// Reset (rst_ni low, asynchronous) empties both sequences and returns to idle.
module longest_common_subsequence #(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lcs_pkg::CMD_W-1:0]   cmd_i,
  input  logic [lcs_pkg::SYM_W-1:0]   symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcs_pkg::SYM_W-1:0]   lcs_symbol_o,
  output logic [lcs_pkg::LEN_W-1:0]   lcs_length_o,
  output logic [lcs_pkg::POS_W-1:0]   position_o,
  output logic                        is_empty_o,
  output logic                        last_o
);

  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned TW = CW + 1;

  lcs_pkg::state_e state_q, state_d;

  logic [CW-1:0] x_cnt_q, x_cnt_d, y_cnt_q, y_cnt_d;
  logic [TW-1:0] tc_q, tc_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, cnt_q, cnt_d, total_q, total_d, k_q, k_d;
  logic          accept;
  logic          cell_clr;
  logic          feed;
  logic          rbuf_we;
  logic          out_load, out_empty_load;

  logic                   inj_valid_q;
  logic [IW-1:0]          inj_row_q;
  logic [SYMBOL_BITS-1:0] y_rd_q, rbuf_rd_q;
  logic [SYMBOL_BITS-1:0] sym_in;
  logic [SYMBOL_BITS-1:0] y_mem [MAX_LEN];
  logic [SYMBOL_BITS-1:0] rbuf  [MAX_LEN];

  // Chain links; index 0 is the row injector.
  logic                   lk_valid [MAX_LEN+1];
  logic [IW-1:0]          lk_row   [MAX_LEN+1];
  logic [SYMBOL_BITS-1:0] lk_y     [MAX_LEN+1];
  logic [CW-1:0]          lk_new   [MAX_LEN+1];
  logic [CW-1:0]          lk_old   [MAX_LEN+1];
  logic [CW-1:0]          len_w    [MAX_LEN];
  logic [SYMBOL_BITS-1:0] xs_w     [MAX_LEN];
  lcs_pkg::dir_e          dir_w    [MAX_LEN];

  logic [IW-1:0] jm1, im1, xm1;
  lcs_pkg::dir_e tb_dir;

  logic                           out_valid_q;
  logic [lcs_pkg::SYM_W-1:0]      sym_out_q;
  logic [lcs_pkg::LEN_W-1:0]      len_out_q;
  logic [lcs_pkg::POS_W-1:0]      pos_out_q;
  logic                           empty_out_q, last_out_q;
  logic [CW+lcs_pkg::LEN_W-1:0]   total_ext;
  logic [CW+lcs_pkg::POS_W-1:0]   k_ext;
  logic [SYMBOL_BITS+lcs_pkg::SYM_W-1:0] sym_out_ext;
  logic [SYMBOL_BITS+lcs_pkg::SYM_W-1:0] sym_in_ext;

  assign accept = in_valid_i && in_ready_o;

  // Symbol width conversion in both directions.
  assign sym_in_ext  = {{SYMBOL_BITS{1'b0}}, symbol_i};
  assign sym_in      = sym_in_ext[SYMBOL_BITS-1:0];
  assign sym_out_ext = {{lcs_pkg::SYM_W{1'b0}}, rbuf_rd_q};
  assign total_ext   = {{lcs_pkg::LEN_W{1'b0}}, total_q};
  assign k_ext       = {{lcs_pkg::POS_W{1'b0}}, k_q};

  assign jm1    = IW'(j_q - CW'(1));
  assign im1    = IW'(i_q - CW'(1));
  assign xm1    = IW'(x_cnt_q - CW'(1));
  assign tb_dir = dir_w[jm1];
  assign feed   = (state_q == lcs_pkg::S_FILL) && (tc_q < TW'(y_cnt_q));

  // Row injector at the head of the chain.
  assign lk_valid[0] = inj_valid_q;
  assign lk_row[0]   = inj_row_q;
  assign lk_y[0]     = y_rd_q;
  assign lk_new[0]   = '0;
  assign lk_old[0]   = '0;

  // The chain of column cells.
  for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
    lcs_cell #(
      .SYMBOL_BITS(SYMBOL_BITS),
      .IW         (IW),
      .CW         (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (cell_clr),
      .ld_x_i     (accept && (cmd_i == lcs_pkg::CMD_APPEND_X) && (x_cnt_q == CW'(c))),
      .x_sym_i    (sym_in),
      .in_valid_i (lk_valid[c]),
      .in_row_i   (lk_row[c]),
      .in_y_i     (lk_y[c]),
      .in_new_i   (lk_new[c]),
      .in_old_i   (lk_old[c]),
      .out_valid_o(lk_valid[c+1]),
      .out_row_o  (lk_row[c+1]),
      .out_y_o    (lk_y[c+1]),
      .out_new_o  (lk_new[c+1]),
      .out_old_o  (lk_old[c+1]),
      .len_o      (len_w[c]),
      .x_o        (xs_w[c]),
      .rd_addr_i  (im1),
      .dir_o      (dir_w[c])
    );
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d        = state_q;
    x_cnt_d        = x_cnt_q;
    y_cnt_d        = y_cnt_q;
    tc_d           = tc_q;
    i_d            = i_q;
    j_d            = j_q;
    cnt_d          = cnt_q;
    total_d        = total_q;
    k_d            = k_q;
    cell_clr       = 1'b0;
    rbuf_we        = 1'b0;
    out_load       = 1'b0;
    out_empty_load = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      lcs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (cmd_i)
            lcs_pkg::CMD_APPEND_X: begin
              if (x_cnt_q < CW'(MAX_LEN)) x_cnt_d = x_cnt_q + CW'(1);
            end
            lcs_pkg::CMD_APPEND_Y: begin
              if (y_cnt_q < CW'(MAX_LEN)) y_cnt_d = y_cnt_q + CW'(1);
            end
            lcs_pkg::CMD_COMPUTE: begin
              cell_clr = 1'b1;
              tc_d     = '0;
              total_d  = '0;
              if (x_cnt_q == '0 || y_cnt_q == '0) begin
                state_d = lcs_pkg::S_EMPTY;
              end else begin
                state_d = lcs_pkg::S_FILL;
              end
            end
            default: ;
          endcase
        end
      end
      lcs_pkg::S_FILL: begin
        tc_d = tc_q + TW'(1);
        if (tc_q == TW'(y_cnt_q) + TW'(MAX_LEN) + TW'(1)) begin
          total_d = len_w[xm1];
          state_d = lcs_pkg::S_CHECK;
        end
      end
      lcs_pkg::S_CHECK: begin
        i_d   = y_cnt_q;
        j_d   = x_cnt_q;
        cnt_d = total_q;
        k_d   = '0;
        state_d = (total_q == '0) ? lcs_pkg::S_EMPTY : lcs_pkg::S_TB_RD;
      end
      lcs_pkg::S_TB_RD: begin
        state_d = lcs_pkg::S_TB_STEP;
      end
      lcs_pkg::S_TB_STEP: begin
        case (tb_dir)
          lcs_pkg::DIR_DIAG: begin
            rbuf_we = (cnt_q != '0);
            if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
            i_d = i_q - CW'(1);
            j_d = j_q - CW'(1);
          end
          lcs_pkg::DIR_UP: i_d = i_q - CW'(1);
          default:         j_d = j_q - CW'(1);
        endcase
        state_d = (i_d == '0 || j_d == '0) ? lcs_pkg::S_EMIT_RD : lcs_pkg::S_TB_RD;
      end
      lcs_pkg::S_EMIT_RD: begin
        state_d = lcs_pkg::S_EMIT_OUT;
      end
      lcs_pkg::S_EMIT_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          k_d      = k_q + CW'(1);
          if (k_q + CW'(1) == total_q) begin
            x_cnt_d = '0;
            y_cnt_d = '0;
            state_d = lcs_pkg::S_IDLE;
          end else begin
            state_d = lcs_pkg::S_EMIT_RD;
          end
        end
      end
      lcs_pkg::S_EMPTY: begin
        if (!out_valid_q || out_ready_i) begin
          out_empty_load = 1'b1;
          x_cnt_d        = '0;
          y_cnt_d        = '0;
          state_d        = lcs_pkg::S_IDLE;
        end
      end
      default: state_d = lcs_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcs_pkg::S_IDLE;
      x_cnt_q     <= '0;
      y_cnt_q     <= '0;
      tc_q        <= '0;
      inj_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_cnt_q     <= x_cnt_d;
      y_cnt_q     <= y_cnt_d;
      tc_q        <= tc_d;
      inj_valid_q <= feed;
      if (out_load || out_empty_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Traceback and emission registers.
  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    cnt_q     <= cnt_d;
    total_q   <= total_d;
    k_q       <= k_d;
    inj_row_q <= tc_q[IW-1:0];
  end

  // Y store: appended while idle, read in row order during fill.
  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == lcs_pkg::CMD_APPEND_Y) && (y_cnt_q < CW'(MAX_LEN))) begin
      y_mem[y_cnt_q[IW-1:0]] <= sym_in;
    end
    y_rd_q <= y_mem[tc_q[IW-1:0]];
  end

  // Result buffer: filled back to front by traceback, read front to back.
  always_ff @(posedge clk_i) begin
    if (rbuf_we) begin
      rbuf[IW'(cnt_q - CW'(1))] <= xs_w[jm1];
    end
    rbuf_rd_q <= rbuf[k_q[IW-1:0]];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sym_out_q   <= sym_out_ext[lcs_pkg::SYM_W-1:0];
      len_out_q   <= total_ext[lcs_pkg::LEN_W-1:0];
      pos_out_q   <= k_ext[lcs_pkg::POS_W-1:0];
      empty_out_q <= 1'b0;
      last_out_q  <= (k_q + CW'(1) == total_q);
    end else if (out_empty_load) begin
      sym_out_q   <= '0;
      len_out_q   <= '0;
      pos_out_q   <= '0;
      empty_out_q <= 1'b1;
      last_out_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lcs_symbol_o = sym_out_q;
  assign lcs_length_o = len_out_q;
  assign position_o   = pos_out_q;
  assign is_empty_o   = empty_out_q;
  assign last_o       = last_out_q;

`ifndef ASSERT_OFF
  // An empty result is always the single, final result with zero length.
  a_empty_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> last_o && (lcs_length_o == '0))
    else $error("empty result not final");

  // Requests are taken only while idle.
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == lcs_pkg::S_IDLE)
    else $error("ready outside idle");

  // Sequence counts never exceed the store depth.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_cnt_q <= CW'(MAX_LEN)) && (y_cnt_q <= CW'(MAX_LEN)))
    else $error("sequence count overflow");

  // Traceback never writes with the collection counter exhausted.
  a_tb_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rbuf_we |-> cnt_q != '0 && cnt_q <= total_q)
    else $error("result buffer write out of range");
`endif

endmodule

[hdl/lcs_cell.sv]
// One column cell of the systolic length table with its direction column memory.
module lcs_cell #(
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned IW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  logic                   ld_x_i,
  input  logic [SYMBOL_BITS-1:0] x_sym_i,
  input  logic                   in_valid_i,
  input  logic [IW-1:0]          in_row_i,
  input  logic [SYMBOL_BITS-1:0] in_y_i,
  input  logic [CW-1:0]          in_new_i,
  input  logic [CW-1:0]          in_old_i,
  output logic                   out_valid_o,
  output logic [IW-1:0]          out_row_o,
  output logic [SYMBOL_BITS-1:0] out_y_o,
  output logic [CW-1:0]          out_new_o,
  output logic [CW-1:0]          out_old_o,
  output logic [CW-1:0]          len_o,
  output logic [SYMBOL_BITS-1:0] x_o,
  input  logic [IW-1:0]          rd_addr_i,
  output lcs_pkg::dir_e          dir_o
);

  localparam int unsigned DEPTH = 1 << IW;

  logic [SYMBOL_BITS-1:0] x_q;
  logic [CW-1:0]          len_q, len_d;
  logic                   valid_q;
  logic [IW-1:0]          row_q;
  logic [SYMBOL_BITS-1:0] y_q;
  logic [CW-1:0]          new_q, old_q;
  lcs_pkg::dir_e          dir_d, dir_q;
  lcs_pkg::dir_e          dir_mem [DEPTH];

  // Cell recurrence: diagonal on match, else the larger of up and left.
  always_comb begin
    if (in_y_i == x_q) begin
      len_d = in_old_i + CW'(1);
      dir_d = lcs_pkg::DIR_DIAG;
    end else if (len_q >= in_new_i) begin
      len_d = len_q;
      dir_d = lcs_pkg::DIR_UP;
    end else begin
      len_d = in_new_i;
      dir_d = lcs_pkg::DIR_LEFT;
    end
  end

  // Control state of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      len_q   <= '0;
    end else begin
      valid_q <= in_valid_i;
      if (clr_i) begin
        len_q <= '0;
      end else if (in_valid_i) begin
        len_q <= len_d;
      end
    end
  end

  // Payload handed to the right neighbor, and the loaded X symbol.
  always_ff @(posedge clk_i) begin
    if (ld_x_i) begin
      x_q <= x_sym_i;
    end
    row_q <= in_row_i;
    y_q   <= in_y_i;
    if (in_valid_i) begin
      new_q <= len_d;
      old_q <= len_q;
    end
  end

  // Direction column: written by row during fill, read during traceback.
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      dir_mem[in_row_i] <= dir_d;
    end
    dir_q <= dir_mem[rd_addr_i];
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign out_y_o     = y_q;
  assign out_new_o   = new_q;
  assign out_old_o   = old_q;
  assign len_o       = len_q;
  assign x_o         = x_q;
  assign dir_o       = dir_q;

endmodule
